/* hw/rtl/bracket_balance_checker_core_macros.svh */
// ----------------------------------------------------------------------------
// Bracket balance checker assertion macros
// Concurrent assertion shorthands; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH
`define BRACKET_BALANCE_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define BBC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bracket checker: same-cycle check failed");
// next-cycle implication
`define BBC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bracket checker: next-cycle check failed");
`else
`define BBC_ASSERT_IMPLY(lbl, ante, cons)
`define BBC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker package
// Status codes, opener kinds and character constants.
// ----------------------------------------------------------------------------
`default_nettype none

package bbc_pkg;

	typedef logic [3:0] status_t;
	typedef logic [1:0] kind_t;
	typedef logic [7:0] char_t;

	localparam logic CMD_CHAR = 1'b0;
	localparam logic CMD_END  = 1'b1;

	localparam status_t ST_PUSHED      = 4'd0;
	localparam status_t ST_POPPED      = 4'd1;
	localparam status_t ST_SKIPPED     = 4'd2;
	localparam status_t ST_EMPTY_CLOSE = 4'd3;
	localparam status_t ST_MISMATCH    = 4'd4;
	localparam status_t ST_OVERFLOW    = 4'd5;
	localparam status_t ST_MATCHED     = 4'd6;
	localparam status_t ST_REMAIN      = 4'd7;
	localparam status_t ST_AFTER_ERR   = 4'd8;

	localparam kind_t KIND_PAREN  = 2'd0;
	localparam kind_t KIND_SQUARE = 2'd1;
	localparam kind_t KIND_BRACE  = 2'd2;

	localparam char_t CH_LPAREN = 8'h28;
	localparam char_t CH_RPAREN = 8'h29;
	localparam char_t CH_LSQUARE = 8'h5B;
	localparam char_t CH_RSQUARE = 8'h5D;
	localparam char_t CH_LBRACE = 8'h7B;
	localparam char_t CH_RBRACE = 8'h7D;

endpackage

`default_nettype wire

/* hw/rtl/bbc_ram.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker RAM
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bbc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* hw/rtl/bracket_balance_checker_core.sv */
// ----------------------------------------------------------------------------
// Bracket balance checker core
// Tracks bracket nesting of a character stream on a bounded opener stack.
//
//   channel  direction  handshake            payload
//   input    in         in_valid/in_ready    cmd, symbol
//   output   out        out_valid/out_ready  status, depth, top_kind, balanced
//
// One request per cycle while in_ready is high; results appear the next cycle.
// The top opener sits in a register, the entry below it is prefetched from
// the stack RAM every cycle, so a pop never waits on a RAM read.
// in_ready drops only while a result is held and out_ready is low.
// Reset clears depth and the error flag; the stack RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bracket_balance_checker_core_macros.svh"

module bracket_balance_checker_core #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               cmd,
	input  wire bbc_pkg::char_t                     symbol,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output bbc_pkg::status_t                        status,
	output logic [$clog2(STACK_DEPTH+1)-1:0]        depth,
	output bbc_pkg::kind_t                          top_kind,
	output logic                                    balanced
);

	import bbc_pkg::*;

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int AW    = $clog2(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);

	logic [CNT_W-1:0] count_q;
	logic             err_q;
	kind_t            top_q;
	logic             use_fwd_q;
	kind_t            fwd_q;
	logic             out_valid_q;
	status_t          status_q;
	logic [CNT_W-1:0] depth_q;
	kind_t            kind_q;
	logic             bal_q;

	logic             acc;
	logic             is_open;
	logic             is_close;
	kind_t            open_kind;
	kind_t            close_kind;
	kind_t            rd_data;
	kind_t            below;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_next;
	logic             err_d;
	kind_t            top_d;
	status_t          st_d;
	kind_t            kind_d;
	logic             bal_d;
	logic             push;
	logic             ram_we;
	logic [CNT_W-1:0] waddr_full;
	logic [CNT_W-1:0] raddr_full;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;

	always_comb begin
		is_open    = 1'b0;
		is_close   = 1'b0;
		open_kind  = KIND_PAREN;
		close_kind = KIND_PAREN;
		unique case (symbol)
			CH_LPAREN: begin
				is_open   = 1'b1;
				open_kind = KIND_PAREN;
			end
			CH_LSQUARE: begin
				is_open   = 1'b1;
				open_kind = KIND_SQUARE;
			end
			CH_LBRACE: begin
				is_open   = 1'b1;
				open_kind = KIND_BRACE;
			end
			CH_RPAREN: begin
				is_close   = 1'b1;
				close_kind = KIND_PAREN;
			end
			CH_RSQUARE: begin
				is_close   = 1'b1;
				close_kind = KIND_SQUARE;
			end
			CH_RBRACE: begin
				is_close   = 1'b1;
				close_kind = KIND_BRACE;
			end
			default: begin
				is_open  = 1'b0;
				is_close = 1'b0;
			end
		endcase
	end

	// entry below the top: forward a write made in the previous cycle
	assign below = use_fwd_q ? fwd_q : rd_data;

	always_comb begin
		count_d = count_q;
		err_d   = err_q;
		top_d   = top_q;
		st_d    = ST_SKIPPED;
		kind_d  = KIND_PAREN;
		bal_d   = 1'b0;
		push    = 1'b0;
		if (cmd == CMD_END) begin
			priority if (err_q) begin
				st_d = ST_AFTER_ERR;
			end else if (count_q == '0) begin
				st_d  = ST_MATCHED;
				bal_d = 1'b1;
			end else begin
				st_d = ST_REMAIN;
			end
			count_d = '0;
			err_d   = 1'b0;
		end else if (err_q) begin
			st_d   = ST_SKIPPED;
			kind_d = (count_q != '0) ? top_q : KIND_PAREN;
		end else if (is_open) begin
			if (count_q == CNT_FULL) begin
				st_d   = ST_OVERFLOW;
				err_d  = 1'b1;
				kind_d = top_q;
			end else begin
				st_d    = ST_PUSHED;
				push    = 1'b1;
				count_d = count_q + CNT_ONE;
				top_d   = open_kind;
				kind_d  = open_kind;
			end
		end else if (count_q == '0) begin
			st_d  = ST_EMPTY_CLOSE;
			err_d = 1'b1;
		end else begin
			kind_d = top_q;
			if (is_close && close_kind != top_q) begin
				st_d  = ST_MISMATCH;
				err_d = 1'b1;
			end else begin
				st_d    = ST_POPPED;
				count_d = count_q - CNT_ONE;
				top_d   = below;
			end
		end
	end

	// spill the old top into the RAM on a push over a non-empty stack
	assign ram_we     = acc && push && (count_q != '0);
	assign waddr_full = count_q - CNT_ONE;
	assign count_next = acc ? count_d : count_q;
	assign raddr_full = count_next - CNT_TWO;

	bbc_ram #(
		.WIDTH ($bits(kind_t)),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (waddr_full[AW-1:0]),
		.wdata (top_q),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= 1'b0;
			use_fwd_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			use_fwd_q <= ram_we;
			if (acc) begin
				count_q <= count_d;
				err_q   <= err_d;
			end
			if (acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_q <= top_q;
		if (acc) begin
			top_q    <= top_d;
			status_q <= st_d;
			depth_q  <= count_d;
			kind_q   <= kind_d;
			bal_q    <= bal_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign depth     = depth_q;
	assign top_kind  = kind_q;
	assign balanced  = bal_q;

	`BBC_ASSERT_IMPLY(a_count_bound, 1'b1, count_q <= CNT_FULL)
	`BBC_ASSERT_NEXT(a_end_clears, acc && cmd == CMD_END, count_q == '0 && !err_q)
	`BBC_ASSERT_NEXT(a_push_top, acc && push, top_q == $past(open_kind))
	`BBC_ASSERT_IMPLY(a_balanced_status, out_valid_q && bal_q, status_q == ST_MATCHED)

endmodule

`default_nettype wire
